[sv/lcr_pkg.sv]
// ----------------------------------------------------------------------------
// lcr_pkg: shared types and constants for the load current regulator
// Register map, command codes, datapath widths and reciprocal constants.
// ----------------------------------------------------------------------------
package lcr_pkg;

    localparam int CHARGE_INTERVAL = 100;
    localparam int TICK_W          = $clog2(CHARGE_INTERVAL + 1);

    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;
    localparam int LIMIT_W   = 12;
    localparam int VOLT_W    = 16;
    localparam int POWER_W   = 28;
    localparam int CURRENT_W = 16;
    localparam int DAC_W     = 8;
    localparam int CHARGE_W  = 32;
    localparam int INTEG_W   = 32;

    localparam logic [LIMIT_W-1:0] CURRENT_LIMIT_RST = 12'd0;
    localparam logic [VOLT_W-1:0]  MIN_VOLTAGE_RST   = 16'd2000;
    localparam logic [POWER_W-1:0] POWER_LIMIT_RST   = 28'd15000000;

    // floor(x / 10) = (x * DIV10_MUL) >> DIV10_SHIFT for any 32-bit x
    localparam logic [31:0] DIV10_MUL   = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;
    localparam int          QUOT_W      = 64 - DIV10_SHIFT;

    // floor(19 * cl / 100) = (cl * FF_MUL) >> FF_SHIFT for 12-bit cl
    localparam logic [21:0] FF_MUL   = 22'd3187687;
    localparam int          FF_SHIFT = 24;
    localparam int          FF_W     = 10;

    localparam int          SP_W       = 32;
    localparam logic [SP_W-1:0] SP_OFFSET = 32'd2000;
    localparam logic [SP_W-2:0] COARSE_SPAN = 31'd4080;
    localparam logic [DAC_W-1:0] DAC_MAX    = 8'hFF;

    typedef enum logic [1:0] {
        REG_CURRENT_LIMIT = 2'd0,
        REG_MIN_VOLTAGE   = 2'd1,
        REG_POWER_LIMIT   = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_ENABLE  = 2'd1,
        CMD_DISABLE = 2'd2
    } t_cmd;

    typedef struct packed {
        logic signed [CURRENT_W-1:0] meas;
        logic [VOLT_W-1:0]           vsrc;
        logic [1:0]                  cmd;
        logic                        clr;
    } t_in_stage;

    typedef struct packed {
        logic signed [INTEG_W-1:0] integ;
        logic                      en;
        logic                      trip;
        logic [CHARGE_W-1:0]       charge;
    } t_ctl_stage;

    typedef struct packed {
        logic [QUOT_W-1:0]   quot;
        logic                neg;
        logic [FF_W-1:0]     ff;
        logic                en;
        logic                trip;
        logic [CHARGE_W-1:0] charge;
    } t_mul_stage;

endpackage

[sv/load_current_pi_regulator_top.sv]
// ----------------------------------------------------------------------------
// load_current_pi_regulator_top: feedforward plus integral current regulator
// Stages after the input register: control/state update (integral and charge
// state loops close here), reciprocal multipliers, set point split.
// Throughput: one item per cycle while the output is not stalled.
// Reset (i_rst_n low, synchronous): pipeline empty, integral, tick counter,
// charge and enable state cleared, registers at their reset values.
// ----------------------------------------------------------------------------
module load_current_pi_regulator_top
    import lcr_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ADDR_W-1:0]           paddr,
    input  logic [DATA_W-1:0]           pwdata,
    output logic [DATA_W-1:0]           prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [CURRENT_W-1:0] i_measured_current,
    input  logic [VOLT_W-1:0]           i_source_voltage,
    input  logic [1:0]                  i_enable_command,
    input  logic                        i_clear_charge,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [DAC_W-1:0]            o_coarse_dac,
    output logic [DAC_W-1:0]            o_fine_dac,
    output logic                        o_output_on,
    output logic                        o_protection_trip,
    output logic [CHARGE_W-1:0]         o_charge_total
);

    logic [LIMIT_W-1:0] r_current_limit;
    logic [VOLT_W-1:0]  r_min_voltage;
    logic [POWER_W-1:0] r_power_limit;

    logic signed [INTEG_W-1:0]  r_integ, n_integ;
    logic [TICK_W-1:0]          r_tick, n_tick;
    logic [CHARGE_W-1:0]        r_charge, n_charge;
    logic                       r_en, n_en;

    logic       r_v0, r_v1, r_v2, r_v3;
    t_in_stage  r_s0;
    t_ctl_stage r_s1, n_s1;
    t_mul_stage r_s2, n_s2;

    logic adv0, adv1, adv2, adv3;
    logic cfg_wr;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_current_limit <= CURRENT_LIMIT_RST;
            r_min_voltage   <= MIN_VOLTAGE_RST;
            r_power_limit   <= POWER_LIMIT_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_CURRENT_LIMIT: r_current_limit <= pwdata[LIMIT_W-1:0];
                REG_MIN_VOLTAGE:   r_min_voltage   <= pwdata[VOLT_W-1:0];
                REG_POWER_LIMIT:   r_power_limit   <= pwdata[POWER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_CURRENT_LIMIT: prdata = DATA_W'(r_current_limit);
            REG_MIN_VOLTAGE:   prdata = DATA_W'(r_min_voltage);
            REG_POWER_LIMIT:   prdata = DATA_W'(r_power_limit);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline flow control
    // ------------------------------------------------------------------
    assign adv3       = !r_v3 || !i_out_stall;
    assign adv2       = !r_v2 || adv3;
    assign adv1       = !r_v1 || adv2;
    assign adv0       = !r_v0 || adv1;
    assign o_in_stall = !adv0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv0) r_v0 <= i_in_valid;
            if (adv1) r_v1 <= r_v0;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    // ------------------------------------------------------------------
    // stage 0: input register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (adv0 && i_in_valid) begin
            r_s0.meas <= i_measured_current;
            r_s0.vsrc <= i_source_voltage;
            r_s0.cmd  <= i_enable_command;
            r_s0.clr  <= i_clear_charge;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: enable, integral, protection, charge
    // ------------------------------------------------------------------
    logic                en_cmd;
    logic signed [17:0]  err;
    logic signed [33:0]  isum;
    logic signed [INTEG_W-1:0] isat;
    logic [POWER_W-1:0]  pwr;
    logic                trip;
    logic [CHARGE_W-1:0] chg_base;

    always_comb begin
        unique case (r_s0.cmd)
            CMD_ENABLE:  en_cmd = 1'b1;
            CMD_DISABLE: en_cmd = 1'b0;
            default:     en_cmd = r_en;
        endcase

        err  = $signed({6'b0, r_current_limit}) - 18'(r_s0.meas);
        isum = 34'(r_integ) + 34'(err);
        if (!isum[33] && (isum[32] || isum[31])) begin
            isat = {1'b0, {(INTEG_W-1){1'b1}}};
        end else if (isum[33] && !(isum[32] && isum[31])) begin
            isat = {1'b1, {(INTEG_W-1){1'b0}}};
        end else begin
            isat = isum[INTEG_W-1:0];
        end

        pwr  = POWER_W'(r_s0.vsrc) * POWER_W'(r_current_limit);
        trip = (r_s0.vsrc < r_min_voltage) || (pwr > r_power_limit);
        n_en = en_cmd && !trip;

        chg_base = r_s0.clr ? '0 : r_charge;
        n_charge = chg_base;
        n_tick   = r_tick;
        n_integ  = '0;
        if (n_en) begin
            n_integ = isat;
            if (r_tick == TICK_W'(CHARGE_INTERVAL)) begin
                n_charge = chg_base + CHARGE_W'(r_s0.meas);
                n_tick   = '0;
            end else begin
                n_tick = r_tick + 1'b1;
            end
        end

        n_s1.integ  = isat;
        n_s1.en     = n_en;
        n_s1.trip   = trip;
        n_s1.charge = n_charge;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ  <= '0;
            r_tick   <= '0;
            r_charge <= '0;
            r_en     <= 1'b0;
        end else if (r_v0 && adv1) begin
            r_integ  <= n_integ;
            r_tick   <= n_tick;
            r_charge <= n_charge;
            r_en     <= n_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v0 && adv1) r_s1 <= n_s1;
    end

    // ------------------------------------------------------------------
    // stage 2: integral / 10 and feedforward 19% by reciprocal multiply
    // ------------------------------------------------------------------
    logic [INTEG_W-1:0] mag;
    logic [63:0]        qprod;
    logic [33:0]        fprod;

    always_comb begin
        mag   = r_s1.integ[INTEG_W-1] ? INTEG_W'(-r_s1.integ) : INTEG_W'(r_s1.integ);
        qprod = 64'(mag) * 64'(DIV10_MUL);
        fprod = 34'(r_current_limit) * 34'(FF_MUL);

        n_s2.quot   = qprod[63:DIV10_SHIFT];
        n_s2.neg    = r_s1.integ[INTEG_W-1];
        n_s2.ff     = fprod[FF_SHIFT +: FF_W];
        n_s2.en     = r_s1.en;
        n_s2.trip   = r_s1.trip;
        n_s2.charge = r_s1.charge;
    end

    always_ff @(posedge i_clk) begin
        if (r_v1 && adv2) r_s2 <= n_s2;
    end

    // ------------------------------------------------------------------
    // stage 3: set point, coarse and fine split, result register
    // ------------------------------------------------------------------
    logic signed [SP_W-1:0] squot;
    logic signed [SP_W-1:0] sp;
    logic [SP_W-2:0]        spc;
    logic [SP_W-2:0]        rem;
    logic [DAC_W-1:0]       coarse, fine;

    always_comb begin
        squot = r_s2.neg ? -SP_W'(r_s2.quot) : SP_W'(r_s2.quot);
        sp    = squot + SP_W'(r_s2.ff) + SP_OFFSET;
        spc   = sp[SP_W-1] ? '0 : sp[SP_W-2:0];
        rem   = spc - COARSE_SPAN;
        if (|spc[SP_W-2:12]) begin
            coarse = DAC_MAX;
            fine   = (|rem[SP_W-2:10]) ? DAC_MAX : rem[9:2];
        end else begin
            coarse = spc[11:4];
            fine   = DAC_W'(spc[3:2]);
        end
        if (!r_s2.en) begin
            coarse = '0;
            fine   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2 && adv3) begin
            o_coarse_dac      <= coarse;
            o_fine_dac        <= fine;
            o_output_on       <= r_s2.en;
            o_protection_trip <= r_s2.trip;
            o_charge_total    <= r_s2.charge;
        end
    end

    assign o_out_valid = r_v3;

endmodule

[sv/lcr_checker.sv]
// ----------------------------------------------------------------------------
// lcr_checker: port-level checks for the load current regulator
// Watches the result channel and reset behavior of the top level.
// ----------------------------------------------------------------------------
module lcr_checker
    import lcr_pkg::*;
(
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [DAC_W-1:0]            o_coarse_dac,
    input logic [DAC_W-1:0]            o_fine_dac,
    input logic                        o_output_on,
    input logic                        o_protection_trip,
    input logic [CHARGE_W-1:0]         o_charge_total
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_coarse_dac)
            && $stable(o_fine_dac) && $stable(o_charge_total))
        else $error("stalled result changed");

    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_output_on |-> o_coarse_dac == '0 && o_fine_dac == '0)
        else $error("nonzero DAC codes while output off");

    a_trip_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_protection_trip |-> !o_output_on)
        else $error("output on during protection trip");

    a_fine_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_coarse_dac != DAC_MAX |-> o_fine_dac < 8'd4)
        else $error("fine code too large below coarse saturation");

endmodule

bind load_current_pi_regulator_top lcr_checker u_lcr_checker (.*);
